@@ hw/rtl/itrd_pkg.sv @@
// shared types, constants and helpers for the integer to radix digits block
`default_nettype none

package itrd_pkg;

   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned RADIX_WIDTH = 6;
   localparam int unsigned CHAR_WIDTH  = 7;
   localparam int unsigned STACK_DEPTH = VALUE_WIDTH;
   localparam int unsigned ADDR_WIDTH  = $clog2(STACK_DEPTH);
   localparam int unsigned COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN    = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX    = RADIX_WIDTH'(36);
   localparam logic [RADIX_WIDTH-1:0] DECIMAL_BASE = RADIX_WIDTH'(10);
   localparam logic [RADIX_WIDTH-1:0] DIGIT_MAX    = RADIX_WIDTH'(9);

   localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = CHAR_WIDTH'(8'h30);
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = CHAR_WIDTH'(8'h61);
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = CHAR_WIDTH'(8'h2D);

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [RADIX_WIDTH-1:0]        radix;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } rsp_payload_type;

   typedef struct packed {
      logic done;
      logic quo_zero;
   } div_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_READ,
      ST_PUT
   } state_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [RADIX_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      if (d > DIGIT_MAX) begin
         c = CHAR_WIDTH'(d) + (CH_LOWER_A - CHAR_WIDTH'(DECIMAL_BASE));
      end else begin
         c = CHAR_WIDTH'(d) + CH_ZERO;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/itrd_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module itrd_ram #(
   parameter int unsigned WIDTH  = 6,
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/itrd_div.sv @@
// bit-serial restoring divider: value by a narrow radix, one quotient bit per cycle
`default_nettype none

module itrd_div
   import itrd_pkg::*;
#(
   parameter int unsigned VALUE_W = VALUE_WIDTH,
   parameter int unsigned RADIX_W = RADIX_WIDTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [VALUE_W-1:0] dividend,
   input  wire logic [RADIX_W-1:0] divisor,
   output logic      [VALUE_W-1:0] quotient,
   output logic      [RADIX_W-1:0] remainder,
   output div_status_type          status
);

   localparam int unsigned STEP_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0] q_ff,   q_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] dvs_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;

   logic [RADIX_W:0] trial;
   logic [RADIX_W:0] diff;
   logic             fits;

   // shift in the next dividend bit, subtract the radix when it fits
   always_comb begin
      trial  = {rem_ff, q_ff[VALUE_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      rem_in = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      q_in   = {q_ff[VALUE_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient        = q_ff;
   assign remainder       = rem_ff;
   assign status.done     = done_ff;
   assign status.quo_zero = (q_ff == '0);

endmodule

`default_nettype wire

@@ hw/rtl/integer_to_radix_digits.sv @@
// top level: converts an integer to ascii digits in base 2 to 36; signed only in base 10
//
//   channel | direction | ports                              | per transfer
//   --------+-----------+------------------------------------+---------------------------
//   req     | in        | req_valid, req_stall, req_payload  | value and radix
//   rsp     | out       | rsp_valid, rsp_stall, rsp_payload  | one character, last flag
//
// each digit of an item takes one pass through the shared divider,
// which produces one quotient bit per cycle; the characters are then read back
// from the digit ram, most significant first, after a minus for a negative decimal value.
// req_stall is low only while the sequencer is idle; the output register lets the next
// item be taken while the final character still waits. rsp_stall only pauses emission.
// synchronous reset clears the sequencer and the output valid; the digit ram needs none.
`default_nettype none

module integer_to_radix_digits
   import itrd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] cnt_dec;
   logic                   neg_ff, neg_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_payload_ff, rsp_payload_in;
   logic                   rsp_load;
   logic                   out_free;

   logic [RADIX_WIDTH-1:0] radix_c;
   logic [VALUE_WIDTH-1:0] value_u;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   neg_c;

   logic                   div_start;
   logic [VALUE_WIDTH-1:0] div_dividend;
   logic [RADIX_WIDTH-1:0] div_divisor;
   logic [VALUE_WIDTH-1:0] div_quotient;
   logic [RADIX_WIDTH-1:0] div_remainder;
   div_status_type         div_st;

   logic                   ram_we;
   logic                   ram_rd;
   logic [RADIX_WIDTH-1:0] ram_rdata;

   // saturate the radix and pick signed or unsigned conversion
   always_comb begin
      value_u = req_payload.value;
      if (req_payload.radix < RADIX_MIN) begin
         radix_c = RADIX_MIN;
      end else if (req_payload.radix > RADIX_MAX) begin
         radix_c = RADIX_MAX;
      end else begin
         radix_c = req_payload.radix;
      end
      neg_c     = (radix_c == DECIMAL_BASE) && value_u[VALUE_WIDTH-1];
      magnitude = neg_c ? (~value_u + 1'b1) : value_u;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_dec  = cnt_ff - 1'b1;

   // the request payload may move on after the transfer, later digits use the held base
   assign div_divisor = (state_ff == ST_IDLE) ? radix_c : radix_ff;

   itrd_div #(
      .VALUE_W (VALUE_WIDTH),
      .RADIX_W (RADIX_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .status    (div_st)
   );

   itrd_ram #(
      .WIDTH (RADIX_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[ADDR_WIDTH-1:0]),
      .wr_data (div_remainder),
      .rd_en   (ram_rd),
      .rd_addr (cnt_dec[ADDR_WIDTH-1:0]),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         neg_ff       <= 1'b0;
         radix_ff     <= RADIX_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         neg_ff       <= neg_in;
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      radix_in       = radix_ff;
      req_stall      = 1'b1;
      div_start      = 1'b0;
      div_dividend   = div_quotient;
      ram_we         = 1'b0;
      ram_rd         = 1'b0;
      rsp_load       = 1'b0;
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               neg_in       = neg_c;
               radix_in     = radix_c;
               cnt_in       = '0;
               div_start    = 1'b1;
               div_dividend = magnitude;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            // one digit per division; a zero value still yields the digit zero
            if (div_st.done) begin
               ram_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (div_st.quo_zero) begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_payload_in.character = CH_MINUS;
               rsp_payload_in.last      = 1'b0;
               state_in                 = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd   = 1'b1;
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_load                 = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_payload_in.character = digit_char(ram_rdata);
               rsp_payload_in.last      = (cnt_ff == COUNT_WIDTH'(1));
               cnt_in                   = cnt_dec;
               state_in                 = (cnt_ff == COUNT_WIDTH'(1)) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // the digit count never outgrows the stack
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= COUNT_WIDTH'(VALUE_WIDTH))
      else $error("digit count beyond stack depth");

   // emission never starts from an empty stack
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_PUT) |-> cnt_ff != '0)
      else $error("emitting with no digits left");

   // the final character of a string is a digit, never the sign
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.last) |-> rsp_payload.character != CH_MINUS)
      else $error("sign marked as last character");

   // an accepted item always starts a division
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_DIV)
      else $error("accepted item did not start a division");

endmodule

`default_nettype wire
